// File: sv/sa_pkg.sv
// ----------------------------------------------------------------------------
// Segment allocator package
// Shared constants and types for the segment table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none
package sa_pkg;
  localparam int MAX_SEGMENTS = 64;
  localparam int ADDR_BITS    = 32;
  localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
  localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FIT   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [0:0] CMD_ALLOC = 1'b0;
  localparam logic [0:0] CMD_FREE  = 1'b1;

  localparam logic [0:0] REG_TOTAL_SIZE = 1'b0;
  localparam logic [0:0] REG_FIT_MODE   = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] length;
    logic                 free;
    logic [31:0]          owner;
  } seg_t;

  // Operation applied to every cell of the row together.
  typedef enum logic [2:0] {
    OP_NONE, OP_INIT, OP_ROT, OP_INSERT, OP_REMOVE, OP_WRITE
  } row_op_t;

  typedef struct packed {
    row_op_t        op;
    logic [IDX_BITS-1:0] idx;
    seg_t           wdata;
    seg_t           idata;
  } row_ctl_t;
endpackage
`default_nettype wire

// File: sv/segment_allocator_fit_policy.sv
// ----------------------------------------------------------------------------
// Segment allocator with fit policy
// Allocate and free segments in an address-ordered row of cells.
// ----------------------------------------------------------------------------
// A zero-size or id-exhausted allocate answers straight from idle; otherwise the
// row makes a full rotation of the MAX_SEGMENTS cells and an apply state follows,
// and a free then walks the table in merge steps (S_MERGE, S_MSTEP). One request at a time.
// The result strobe lasts one cycle; the receiver cannot stall.
// Synchronous reset restores a single free 65536-byte segment and first fit.
`default_nettype none
module segment_allocator_fit_policy (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_request_size,
  input  wire logic [31:0] in_release_id,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [31:0]      out_address,
  output logic [31:0]      out_granted_id,
  output logic [31:0]      out_success_count,
  output logic [31:0]      out_fail_count
);
  localparam int N = sa_pkg::MAX_SEGMENTS;
  localparam int IB = sa_pkg::IDX_BITS;
  sa_pkg::row_ctl_t ctl;
  sa_pkg::seg_t segs [N];
  sa_pkg::seg_t sel_r, nxt_r;
  logic [IB-1:0] rd_idx;

  // While reset is held the row is loaded with the default table.
  sa_pkg::row_ctl_t ctl_c;
  always_comb begin
    ctl_c = ctl;
    if (!rst_n) begin
      ctl_c = '0;
      ctl_c.op = sa_pkg::OP_INIT;
      ctl_c.wdata.length = 32'd65536;
      ctl_c.wdata.free = 1'b1;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    sa_cell u_cell (
      .clk(clk), .my_idx(IB'(g)), .ctl(ctl_c),
      .left_i(segs[(g + N - 1) % N]), .right_i(segs[(g + 1) % N]), .seg_o(segs[g]));
  end

  // Random reads of the row are registered.
  always_ff @(posedge clk) begin
    sel_r <= segs[rd_idx];
    nxt_r <= segs[rd_idx + 1'b1];
  end

  sa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_cmd(in_cmd),
    .in_request_size(in_request_size), .in_release_id(in_release_id),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .head(segs[0]), .sel_seg(sel_r), .nxt_seg(nxt_r), .ctl(ctl),
    .rd_idx(rd_idx), .busy(busy), .out_valid(out_valid), .out_status(out_status),
    .out_address(out_address), .out_granted_id(out_granted_id),
    .out_success_count(out_success_count), .out_fail_count(out_fail_count));

  a_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sa_pkg::ST_OK |-> out_address == '0 && out_granted_id == '0)
    else $error("failed result carries an address");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start |=> !out_valid)
    else $error("result without a request");
endmodule
`default_nettype wire

// File: sv/sa_cell.sv
// ----------------------------------------------------------------------------
// Segment cell
// Holds one table entry; is initialised or written, or shifts, inserts or rotates with its neighbours.
// ----------------------------------------------------------------------------
`default_nettype none
module sa_cell (
  input  wire logic                        clk,
  input  wire logic [sa_pkg::IDX_BITS-1:0] my_idx,
  input  wire sa_pkg::row_ctl_t            ctl,
  input  wire sa_pkg::seg_t                left_i,
  input  wire sa_pkg::seg_t                right_i,
  output sa_pkg::seg_t                     seg_o
);
  sa_pkg::seg_t seg_r, seg_nxt;

  always_comb begin
    seg_nxt = seg_r;
    case (ctl.op)
      sa_pkg::OP_INIT:   seg_nxt = (my_idx == '0) ? ctl.wdata : '0;
      sa_pkg::OP_ROT:    seg_nxt = right_i;
      sa_pkg::OP_INSERT: begin
        if (my_idx > ctl.idx + 1'b1) seg_nxt = left_i;
        else if (my_idx == ctl.idx + 1'b1) seg_nxt = ctl.idata;
        else if (my_idx == ctl.idx) seg_nxt = ctl.wdata;
      end
      sa_pkg::OP_REMOVE: begin
        if (my_idx >= ctl.idx) seg_nxt = right_i;
        if (my_idx == ctl.idx - 1'b1) seg_nxt = ctl.wdata;
      end
      sa_pkg::OP_WRITE:  if (my_idx == ctl.idx) seg_nxt = ctl.wdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end
  assign seg_o = seg_r;
endmodule
`default_nettype wire

// File: sv/sa_ctrl.sv
// ----------------------------------------------------------------------------
// Segment allocator sequencer
// Scans the rotating cell row at index zero and issues row operations.
// ----------------------------------------------------------------------------
`default_nettype none
module sa_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        in_cmd,
  input  wire logic [31:0]                 in_request_size,
  input  wire logic [31:0]                 in_release_id,
  input  wire logic                        cfg_we,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [31:0]                 cfg_wdata,
  input  wire sa_pkg::seg_t                head,
  input  wire sa_pkg::seg_t                sel_seg,
  input  wire sa_pkg::seg_t                nxt_seg,
  output sa_pkg::row_ctl_t                 ctl,
  output logic [sa_pkg::IDX_BITS-1:0]      rd_idx,
  output logic                             busy,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [31:0]                      out_address,
  output logic [31:0]                      out_granted_id,
  output logic [31:0]                      out_success_count,
  output logic [31:0]                      out_fail_count
);
  localparam int IB = sa_pkg::IDX_BITS;
  localparam int CB = sa_pkg::CNT_BITS;
  localparam logic [CB-1:0] MAXS = CB'(sa_pkg::MAX_SEGMENTS);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_MERGE, S_MSTEP} state_t;
  state_t state_r;

  logic [CB-1:0] cnt_r, pos_r;
  logic [1:0]    fit_r;
  logic [31:0]   nid_r, ok_r, miss_r, size_r, rel_r;
  logic          cmd_r, found_r;
  logic [IB-1:0] ch_r, mi_r;
  logic [31:0]   score_r;
  sa_pkg::seg_t  pick_r;

  logic cand, better;
  logic [31:0] slack;

  // The row rotates left by one each scan cycle, so the entry at pos_r is at cell 0.
  always_comb begin
    slack = head.length - size_r;
    if (cmd_r == sa_pkg::CMD_ALLOC) cand = head.free && head.length >= size_r;
    else cand = !head.free && head.owner == rel_r;
    better = 1'b0;
    if (cand) begin
      if (cmd_r == sa_pkg::CMD_FREE || fit_r == sa_pkg::FIT_FIRST) better = !found_r;
      else if (fit_r == sa_pkg::FIT_BEST) better = !found_r || slack < score_r;
      else if (fit_r == sa_pkg::FIT_WORST) better = !found_r || head.length > score_r;
    end
  end

  // Merge reads come back registered, so each merge step passes through S_MERGE before S_MSTEP.
  always_comb begin
    ctl = '0;
    ctl.op = sa_pkg::OP_NONE;
    rd_idx = mi_r;
    if (cfg_we && cfg_index == sa_pkg::REG_TOTAL_SIZE) begin
      ctl.op = sa_pkg::OP_INIT;
      ctl.wdata.length = cfg_wdata;
      ctl.wdata.free = 1'b1;
    end else if (state_r == S_SCAN) begin
      ctl.op = sa_pkg::OP_ROT;
    end else if (state_r == S_APPLY && found_r) begin
      ctl.idx = ch_r;
      ctl.wdata = pick_r;
      if (cmd_r == sa_pkg::CMD_ALLOC) begin
        ctl.wdata.free = 1'b0;
        ctl.wdata.owner = nid_r;
        ctl.wdata.length = size_r;
        if (pick_r.length != size_r && cnt_r < MAXS) begin
          ctl.op = sa_pkg::OP_INSERT;
          ctl.idata.start = pick_r.start + size_r;
          ctl.idata.length = pick_r.length - size_r;
          ctl.idata.free = 1'b1;
        end else if (pick_r.length == size_r) ctl.op = sa_pkg::OP_WRITE;
      end else begin
        ctl.op = sa_pkg::OP_WRITE;
        ctl.wdata.free = 1'b1;
        ctl.wdata.owner = '0;
      end
    end else if (state_r == S_MSTEP && {1'b0, mi_r} + 1'b1 < cnt_r
                 && sel_seg.free && nxt_seg.free) begin
      ctl.op = sa_pkg::OP_REMOVE;
      ctl.idx = mi_r + 1'b1;
      ctl.wdata = sel_seg;
      ctl.wdata.length = sel_seg.length + nxt_seg.length;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; fit_r <= sa_pkg::FIT_FIRST;
      cnt_r <= CB'(1); nid_r <= 32'd1; ok_r <= '0; miss_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we && cfg_index == sa_pkg::REG_TOTAL_SIZE) begin
        cnt_r <= CB'(1); nid_r <= 32'd1;
        ok_r <= '0; miss_r <= '0;
      end else if (cfg_we) fit_r <= cfg_wdata[1:0];
      case (state_r)
        S_IDLE: if (start) begin
          cmd_r <= in_cmd; size_r <= in_request_size; rel_r <= in_release_id;
          found_r <= 1'b0; pos_r <= '0; ch_r <= '0; score_r <= '0;
          if (in_cmd == sa_pkg::CMD_ALLOC && (in_request_size == '0 || nid_r == '0)) begin
            out_valid <= 1'b1; out_address <= '0; out_granted_id <= '0;
            out_status <= (in_request_size == '0) ? sa_pkg::ST_ZERO : sa_pkg::ST_FULL;
            out_success_count <= ok_r;
            out_fail_count <= miss_r + {31'd0, miss_r != '1};
            if (miss_r != '1) miss_r <= miss_r + 1'b1;
          end else state_r <= S_SCAN;
        end
        S_SCAN: begin
          // Every cell sees a full rotation so the row returns to its order.
          if (pos_r < cnt_r && better) begin
            found_r <= 1'b1; ch_r <= pos_r[IB-1:0]; pick_r <= head;
            score_r <= (fit_r == sa_pkg::FIT_BEST) ? slack : head.length;
          end
          pos_r <= pos_r + 1'b1;
          if (pos_r == MAXS - 1'b1) state_r <= S_APPLY;
        end
        S_APPLY: begin
          out_valid <= 1'b1; out_granted_id <= '0; out_address <= '0;
          out_success_count <= ok_r; out_fail_count <= miss_r;
          state_r <= S_IDLE;
          if (cmd_r == sa_pkg::CMD_FREE) begin
            if (found_r) begin
              out_status <= sa_pkg::ST_OK; out_address <= pick_r.start;
              mi_r <= '0; state_r <= S_MERGE; out_valid <= 1'b0;
            end else out_status <= sa_pkg::ST_UNKNOWN;
          end else if (!found_r || (pick_r.length != size_r && cnt_r >= MAXS)) begin
            out_status <= found_r ? sa_pkg::ST_FULL : sa_pkg::ST_NO_FIT;
            out_fail_count <= miss_r + {31'd0, miss_r != '1};
            if (miss_r != '1) miss_r <= miss_r + 1'b1;
          end else begin
            out_status <= sa_pkg::ST_OK; out_address <= pick_r.start;
            out_granted_id <= nid_r; nid_r <= nid_r + 1'b1;
            if (pick_r.length != size_r) cnt_r <= cnt_r + 1'b1;
            out_success_count <= ok_r + {31'd0, ok_r != '1};
            if (ok_r != '1) ok_r <= ok_r + 1'b1;
          end
        end
        S_MERGE: state_r <= S_MSTEP;
        S_MSTEP: begin
          if ({1'b0, mi_r} + 1'b1 >= cnt_r) begin
            out_valid <= 1'b1; state_r <= S_IDLE;
          end else begin
            if (sel_seg.free && nxt_seg.free) cnt_r <= cnt_r - 1'b1;
            else mi_r <= mi_r + 1'b1;
            state_r <= S_MERGE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
